// ----- hdl/sparse_product_dependency_merge_top_macros.svh -----
// Assertion macros for the sparse product dependency merge block.
// Used by the top level only; expects clk and rst in scope.
`ifndef SPARSE_PRODUCT_DEPENDENCY_MERGE_TOP_MACROS_SVH
`define SPARSE_PRODUCT_DEPENDENCY_MERGE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define SPDM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spdm assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define SPDM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spdm assertion failed");
`else
`define SPDM_ASSERT_NOW(label, ante, cons)
`define SPDM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/spdm_pkg.sv -----
// Shared types and constants of the sparse product dependency merge block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spdm_pkg;

  localparam int ACT_W  = 3;
  localparam int SLOT_W = 11;
  localparam int PTR_W  = 11;
  localparam int COL_W  = 8;
  localparam int ROW_W  = 8;
  localparam int BITS_W = 64;

  localparam logic [ACT_W-1:0] ACT_LOAD_LEFT_START  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_LEFT_ENTRY  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LOAD_RIGHT_START = 3'd2;
  localparam logic [ACT_W-1:0] ACT_LOAD_RIGHT_ENTRY = 3'd3;
  localparam logic [ACT_W-1:0] ACT_COMPUTE          = 3'd4;

  // Decoded command, high only in the cycle an item is accepted.
  typedef struct packed {
    logic load_left_start;
    logic load_left_entry;
    logic load_right_start;
    logic load_right_entry;
    logic compute;
  } spdm_cmd_t;

  typedef struct packed {
    logic active;
    logic done;
  } spdm_merge_stat_t;

endpackage
`default_nettype wire

// ----- hdl/spdm_ptr_unit.sv -----
// Row start pointer store for both matrices and row range fetch.
// Depends on spdm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spdm_ptr_unit #(
  parameter int MAX_NONZEROS = 1024,
  parameter int MAX_DIM      = 256,
  parameter int NZ_W         = 11
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire spdm_pkg::spdm_cmd_t        cmd,
  input  wire logic [spdm_pkg::SLOT_W-1:0] slot,
  input  wire logic [spdm_pkg::PTR_W-1:0]  index_value,
  input  wire logic [spdm_pkg::ROW_W-1:0]  out_row,
  input  wire logic [spdm_pkg::ROW_W-1:0]  out_column,
  output logic                            rng_valid,
  output logic [NZ_W-1:0]                 a_start,
  output logic [NZ_W-1:0]                 a_end,
  output logic [NZ_W-1:0]                 b_start,
  output logic [NZ_W-1:0]                 b_end,
  output logic                            active
);
  import spdm_pkg::*;

  localparam int PD   = 2 * (MAX_DIM + 1);
  localparam int PA_W = $clog2(PD);

  typedef enum logic [2:0] {
    P_IDLE  = 3'b001,
    P_LEFT  = 3'b010,
    P_RIGHT = 3'b100
  } ptr_state_t;

  ptr_state_t state, state_next;

  logic [PTR_W-1:0] mem [PD];
  logic             we, re;
  logic [PA_W-1:0]  waddr, ra0, ra1;
  logic [PTR_W-1:0] rd0, rd1;

  logic [ROW_W-1:0] col_q;
  logic             rng_ok_q;
  logic [NZ_W-1:0]  a_start_q, a_end_q;
  logic [31:0]      slot_ext, row_ext, col_ext, colq_ext;
  logic             row_ok, col_ok;

  function automatic logic [NZ_W-1:0] clamp_ptr(input logic [PTR_W-1:0] p);
    logic [NZ_W-1:0] r;
    if (32'(p) > 32'(MAX_NONZEROS)) r = NZ_W'(MAX_NONZEROS);
    else r = NZ_W'(p);
    return r;
  endfunction

  assign slot_ext = 32'(slot);
  assign row_ext  = 32'(out_row);
  assign col_ext  = 32'(out_column);
  assign colq_ext = 32'(col_q);
  assign row_ok   = row_ext < 32'(MAX_DIM);
  assign col_ok   = col_ext < 32'(MAX_DIM);

  // Left starts sit at 0..MAX_DIM, right starts follow them.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    if (cmd.load_left_start && slot_ext <= 32'(MAX_DIM)) begin
      we    = 1'b1;
      waddr = PA_W'(slot_ext);
    end else if (cmd.load_right_start && slot_ext <= 32'(MAX_DIM)) begin
      we    = 1'b1;
      waddr = PA_W'(slot_ext + 32'(MAX_DIM) + 32'd1);
    end
  end

  always_comb begin
    state_next = state;
    re         = 1'b0;
    ra0        = '0;
    ra1        = '0;
    rng_valid  = 1'b0;
    a_start    = '0;
    a_end      = '0;
    b_start    = '0;
    b_end      = '0;
    case (state)
      P_IDLE: begin
        if (cmd.compute) begin
          re = 1'b1;
          if (row_ok && col_ok) begin
            ra0 = PA_W'(row_ext);
            ra1 = PA_W'(row_ext + 32'd1);
          end
          state_next = P_LEFT;
        end
      end
      P_LEFT: begin
        re = 1'b1;
        if (rng_ok_q) begin
          ra0 = PA_W'(colq_ext + 32'(MAX_DIM) + 32'd1);
          ra1 = PA_W'(colq_ext + 32'(MAX_DIM) + 32'd2);
        end
        state_next = P_RIGHT;
      end
      P_RIGHT: begin
        rng_valid = 1'b1;
        // Out-of-range rows or columns give empty lists and so a zero result.
        if (rng_ok_q) begin
          a_start = a_start_q;
          a_end   = a_end_q;
          b_start = clamp_ptr(rd0);
          b_end   = clamp_ptr(rd1);
        end
        state_next = P_IDLE;
      end
      default: state_next = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= index_value;
    if (re) begin
      rd0 <= mem[ra0];
      rd1 <= mem[ra1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == P_IDLE && cmd.compute) begin
      col_q    <= out_column;
      rng_ok_q <= row_ok && col_ok;
    end
    if (state == P_LEFT) begin
      a_start_q <= clamp_ptr(rd0);
      a_end_q   <= clamp_ptr(rd1);
    end
  end

  assign active = (state != P_IDLE);

endmodule
`default_nettype wire

// ----- hdl/spdm_merge_unit.sv -----
// Entry store for both matrices and the sorted-list merge that ORs bit vectors.
// Depends on spdm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spdm_merge_unit #(
  parameter int MAX_NONZEROS = 1024,
  parameter int NZ_W         = 11
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire spdm_pkg::spdm_cmd_t          cmd,
  input  wire logic [spdm_pkg::SLOT_W-1:0]  slot,
  input  wire logic [spdm_pkg::PTR_W-1:0]   index_value,
  input  wire logic [spdm_pkg::BITS_W-1:0]  entry_bits,
  input  wire logic                         rng_valid,
  input  wire logic [NZ_W-1:0]              a_start,
  input  wire logic [NZ_W-1:0]              a_end,
  input  wire logic [NZ_W-1:0]              b_start,
  input  wire logic [NZ_W-1:0]              b_end,
  output logic [spdm_pkg::BITS_W-1:0]       dependency_bits,
  output spdm_pkg::spdm_merge_stat_t        stat
);
  import spdm_pkg::*;

  localparam int ED    = 2 * MAX_NONZEROS;
  localparam int EA_W  = (ED > 1) ? $clog2(ED) : 1;
  localparam int ENT_W = COL_W + BITS_W;

  typedef enum logic [1:0] {
    M_IDLE = 2'b01,
    M_RUN  = 2'b10
  } merge_state_t;

  merge_state_t state, state_next;

  logic [ENT_W-1:0] mem [ED];
  logic             we, re;
  logic [EA_W-1:0]  waddr, ra0, ra1;
  logic [ENT_W-1:0] wdata, rd0, rd1;

  logic [NZ_W-1:0]   a, b, a_end_q, b_end_q;
  logic [NZ_W-1:0]   a_next, b_next, a_end_next, b_end_next;
  logic [BITS_W-1:0] acc, acc_next;
  logic [COL_W-1:0]  ka, kb;
  logic              finish;
  logic              done;
  logic [31:0]       slot_ext;

  assign slot_ext = 32'(slot);
  assign wdata    = {index_value[COL_W-1:0], entry_bits};
  assign ka       = rd0[ENT_W-1 -: COL_W];
  assign kb       = rd1[ENT_W-1 -: COL_W];

  // Left entries at 0..MAX_NONZEROS-1, right entries above them.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    if (cmd.load_left_entry && slot_ext < 32'(MAX_NONZEROS)) begin
      we    = 1'b1;
      waddr = EA_W'(slot_ext);
    end else if (cmd.load_right_entry && slot_ext < 32'(MAX_NONZEROS)) begin
      we    = 1'b1;
      waddr = EA_W'(slot_ext + 32'(MAX_NONZEROS));
    end
  end

  always_comb begin
    state_next = state;
    a_next     = a;
    b_next     = b;
    a_end_next = a_end_q;
    b_end_next = b_end_q;
    acc_next   = acc;
    finish     = 1'b0;
    re         = 1'b0;
    case (state)
      M_IDLE: begin
        if (rng_valid) begin
          a_next     = a_start;
          b_next     = b_start;
          a_end_next = a_end;
          b_end_next = b_end;
          acc_next   = '0;
          state_next = M_RUN;
        end
      end
      M_RUN: begin
        // Data for (a, b) is on the read ports in this cycle.
        if (a < a_end_q && b < b_end_q) begin
          if (ka == kb) begin
            acc_next = acc | rd0[BITS_W-1:0] | rd1[BITS_W-1:0];
            a_next   = a + 1'b1;
            b_next   = b + 1'b1;
          end else if (ka < kb) begin
            a_next = a + 1'b1;
          end else begin
            b_next = b + 1'b1;
          end
        end else begin
          finish     = 1'b1;
          state_next = M_IDLE;
        end
      end
      default: state_next = M_IDLE;
    endcase
    // Fetch the next pair only while both lists still have entries.
    if (state_next == M_RUN && a_next < a_end_next && b_next < b_end_next) re = 1'b1;
  end

  assign ra0 = EA_W'(a_next);
  assign ra1 = EA_W'(32'(b_next) + 32'(MAX_NONZEROS));

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) begin
      rd0 <= mem[ra0];
      rd1 <= mem[ra1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    a       <= a_next;
    b       <= b_next;
    a_end_q <= a_end_next;
    b_end_q <= b_end_next;
    acc     <= acc_next;
    if (finish) dependency_bits <= acc;
  end

  assign stat.active = (state != M_IDLE);
  assign stat.done   = done;

endmodule
`default_nettype wire

// ----- hdl/sparse_product_dependency_merge_top.sv -----
// Compute item: the pointer unit fetches the left, then the right row range, then the
// merge takes at most as many steps as the two row lengths sum to and strobes done;
// busy holds meanwhile. The merge takes one step per cycle, paced by the entry memory's
// two read ports. Loads leave busy low and, outside a compute, stream at one per cycle.
// Synchronous reset clears control only; stores are undefined until loaded.
// The result strobe is shown for exactly one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_product_dependency_merge_top_macros.svh"
module sparse_product_dependency_merge_top #(
  parameter int MAX_NONZEROS = 1024,
  parameter int MAX_DIM      = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  output logic                               done,
  input  wire logic [spdm_pkg::ACT_W-1:0]    action,
  input  wire logic [spdm_pkg::SLOT_W-1:0]   slot,
  input  wire logic [spdm_pkg::PTR_W-1:0]    index_value,
  input  wire logic [spdm_pkg::BITS_W-1:0]   entry_bits,
  input  wire logic [spdm_pkg::ROW_W-1:0]    out_row,
  input  wire logic [spdm_pkg::ROW_W-1:0]    out_column,
  output logic [spdm_pkg::BITS_W-1:0]        dependency_bits
);
  import spdm_pkg::*;

  localparam int NZ_W = $clog2(MAX_NONZEROS + 1);

  logic             accept;
  spdm_cmd_t        cmd;
  logic             rng_valid, ptr_active;
  logic [NZ_W-1:0]  a_start, a_end, b_start, b_end;
  spdm_merge_stat_t mstat;

  assign accept = start && !busy;

  always_comb begin
    cmd = '0;
    if (accept) begin
      case (action)
        ACT_LOAD_LEFT_START:  cmd.load_left_start  = 1'b1;
        ACT_LOAD_LEFT_ENTRY:  cmd.load_left_entry  = 1'b1;
        ACT_LOAD_RIGHT_START: cmd.load_right_start = 1'b1;
        ACT_LOAD_RIGHT_ENTRY: cmd.load_right_entry = 1'b1;
        ACT_COMPUTE:          cmd.compute          = 1'b1;
        default:              cmd = '0;
      endcase
    end
  end

  spdm_ptr_unit #(
    .MAX_NONZEROS (MAX_NONZEROS),
    .MAX_DIM      (MAX_DIM),
    .NZ_W         (NZ_W)
  ) u_ptr (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .slot        (slot),
    .index_value (index_value),
    .out_row     (out_row),
    .out_column  (out_column),
    .rng_valid   (rng_valid),
    .a_start     (a_start),
    .a_end       (a_end),
    .b_start     (b_start),
    .b_end       (b_end),
    .active      (ptr_active)
  );

  spdm_merge_unit #(
    .MAX_NONZEROS (MAX_NONZEROS),
    .NZ_W         (NZ_W)
  ) u_merge (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .slot            (slot),
    .index_value     (index_value),
    .entry_bits      (entry_bits),
    .rng_valid       (rng_valid),
    .a_start         (a_start),
    .a_end           (a_end),
    .b_start         (b_start),
    .b_end           (b_end),
    .dependency_bits (dependency_bits),
    .stat            (mstat)
  );

  assign busy = ptr_active || mstat.active;
  assign done = mstat.done;

  `SPDM_ASSERT_NEXT(a_compute_sets_busy, start && !busy && action == ACT_COMPUTE, busy)
  `SPDM_ASSERT_NOW(a_done_after_busy, done, $past(busy))
  `SPDM_ASSERT_NEXT(a_load_gives_no_result, start && !busy && action != ACT_COMPUTE, !done)

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking bench for sparse_product_dependency_merge_top: loads compressed-row
// patterns on both sides, issues merge computes and checks every dependency result.
// Depends on spdm_pkg and the top level only.
`timescale 1ns / 1ps
module tb_top;
  import spdm_pkg::*;

  localparam int NNZ = 1024;
  localparam int DIM = 256;
  localparam int LEFT_SIDE = 0;
  localparam int RIGHT_SIDE = 1;
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;
  localparam int ITEM_TARGET = 1150;
  localparam int DRAIN_EVERY = 250;
  // ~1150 items, each at its longest gap, pointer fetch and merge; keep 4x headroom
  localparam int CYCLE_LIMIT = 10_000_000;

  typedef struct {
    bit [ACT_W-1:0]  act;
    bit [SLOT_W-1:0] addr;
    bit [PTR_W-1:0]  val;
    bit [BITS_W-1:0] bits;
    bit [ROW_W-1:0]  row;
    bit [ROW_W-1:0]  column;
    bit              drain;
  } spdm_item_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic                done;
  logic [ACT_W-1:0]    action = '0;
  logic [SLOT_W-1:0]   slot = '0;
  logic [PTR_W-1:0]    index_value = '0;
  logic [BITS_W-1:0]   entry_bits = '0;
  logic [ROW_W-1:0]    out_row = '0;
  logic [ROW_W-1:0]    out_column = '0;
  logic [BITS_W-1:0]   dependency_bits;

  sparse_product_dependency_merge_top #(
    .MAX_NONZEROS(NNZ),
    .MAX_DIM(DIM)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .done(done),
    .action(action),
    .slot(slot),
    .index_value(index_value),
    .entry_bits(entry_bits),
    .out_row(out_row),
    .out_column(out_column),
    .dependency_bits(dependency_bits)
  );

  initial forever #6 clk = ~clk;

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: both matrices as the block should hold them
  bit [PTR_W-1:0]  row_start_mem [0:1][0:DIM];
  bit [COL_W-1:0]  column_mem    [0:1][0:NNZ-1];
  bit [BITS_W-1:0] dep_mem       [0:1][0:NNZ-1];
  bit [BITS_W-1:0] bits_due [$];

  // Generator view: what has been written, so no compute reads an unwritten entry
  bit              start_known [0:1][0:DIM];
  bit [PTR_W-1:0]  start_plan  [0:1][0:DIM];
  bit              entry_known [0:1][0:NNZ-1];
  spdm_item_t      command_queue [$];
  bit              drain_next = 1'b0;
  int              recent_row [0:1];

  int  planned_count = 0;
  int  accepted_count = 0;
  int  compute_count = 0;
  int  results_checked = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  bit  item_taken = 1'b0;

  function automatic int unsigned pointer_limit(bit [PTR_W-1:0] p);
    return (p > NNZ) ? NNZ : p;
  endfunction

  function automatic bit [BITS_W-1:0] merged_dependency(int row, int column);
    int unsigned a, a_end, b, b_end;
    bit [BITS_W-1:0] acc;
    acc = '0;
    if (row >= DIM || column >= DIM) return acc;
    a = pointer_limit(row_start_mem[LEFT_SIDE][row]);
    a_end = pointer_limit(row_start_mem[LEFT_SIDE][row + 1]);
    b = pointer_limit(row_start_mem[RIGHT_SIDE][column]);
    b_end = pointer_limit(row_start_mem[RIGHT_SIDE][column + 1]);
    while (a < a_end && b < b_end) begin
      if (column_mem[LEFT_SIDE][a] == column_mem[RIGHT_SIDE][b]) begin
        acc |= dep_mem[LEFT_SIDE][a] | dep_mem[RIGHT_SIDE][b];
        a++;
        b++;
      end else if (column_mem[LEFT_SIDE][a] < column_mem[RIGHT_SIDE][b]) begin
        a++;
      end else begin
        b++;
      end
    end
    return acc;
  endfunction

  function automatic void absorb_item(bit [ACT_W-1:0] act, bit [SLOT_W-1:0] addr,
                                      bit [PTR_W-1:0] val, bit [BITS_W-1:0] bits,
                                      bit [ROW_W-1:0] row, bit [ROW_W-1:0] column);
    case (act)
      ACT_LOAD_LEFT_START: if (addr <= DIM) row_start_mem[LEFT_SIDE][addr] = val;
      ACT_LOAD_RIGHT_START: if (addr <= DIM) row_start_mem[RIGHT_SIDE][addr] = val;
      ACT_LOAD_LEFT_ENTRY: if (addr < NNZ) begin
        column_mem[LEFT_SIDE][addr] = val[COL_W-1:0];
        dep_mem[LEFT_SIDE][addr] = bits;
      end
      ACT_LOAD_RIGHT_ENTRY: if (addr < NNZ) begin
        column_mem[RIGHT_SIDE][addr] = val[COL_W-1:0];
        dep_mem[RIGHT_SIDE][addr] = bits;
      end
      ACT_COMPUTE: begin
        bits_due.push_back(merged_dependency(row, column));
        compute_count++;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  function automatic bit [BITS_W-1:0] random64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit [BITS_W-1:0] entry_pattern();
    if ($urandom_range(0, 1) == 0) return 64'd1 << $urandom_range(0, 63);
    return random64();
  endfunction

  // Only the low 8 bits are a column; sometimes dirty the upper bits
  function automatic bit [PTR_W-1:0] column_code(bit [COL_W-1:0] col);
    if ($urandom_range(0, 3) == 0) return {3'($urandom_range(1, 7)), col};
    return {3'b000, col};
  endfunction

  function automatic bit [ACT_W-1:0] start_code(int side);
    return (side == LEFT_SIDE) ? ACT_LOAD_LEFT_START : ACT_LOAD_RIGHT_START;
  endfunction

  function automatic bit [ACT_W-1:0] entry_code(int side);
    return (side == LEFT_SIDE) ? ACT_LOAD_LEFT_ENTRY : ACT_LOAD_RIGHT_ENTRY;
  endfunction

  function automatic bit row_readable(int side, int row);
    int unsigned lo, hi;
    if (row >= DIM) return 1'b1;
    if (!start_known[side][row] || !start_known[side][row + 1]) return 1'b0;
    lo = pointer_limit(start_plan[side][row]);
    hi = pointer_limit(start_plan[side][row + 1]);
    for (int unsigned k = lo; k < hi; k++)
      if (!entry_known[side][k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void queue_load(bit [ACT_W-1:0] act, int addr, int val,
                                     bit [BITS_W-1:0] bits);
    spdm_item_t it;
    int side;
    it.act = act;
    it.addr = SLOT_W'(addr);
    it.val = PTR_W'(val);
    it.bits = bits;
    it.row = ROW_W'($urandom);
    it.column = ROW_W'($urandom);
    it.drain = drain_next;
    drain_next = 1'b0;
    side = (act == ACT_LOAD_LEFT_START || act == ACT_LOAD_LEFT_ENTRY) ? LEFT_SIDE : RIGHT_SIDE;
    if ((act == ACT_LOAD_LEFT_START || act == ACT_LOAD_RIGHT_START) && it.addr <= DIM) begin
      start_known[side][it.addr] = 1'b1;
      start_plan[side][it.addr] = it.val;
    end else if ((act == ACT_LOAD_LEFT_ENTRY || act == ACT_LOAD_RIGHT_ENTRY) &&
                 it.addr < NNZ) begin
      entry_known[side][it.addr] = 1'b1;
    end
    command_queue.push_back(it);
  endfunction

  // Queue a compute only if every store entry it touches has been written
  function automatic bit queue_probe(int row, int column);
    spdm_item_t it;
    if (!row_readable(LEFT_SIDE, row) || !row_readable(RIGHT_SIDE, column)) return 1'b0;
    it.act = ACT_COMPUTE;
    it.addr = SLOT_W'($urandom);
    it.val = PTR_W'($urandom);
    it.bits = random64();
    it.row = ROW_W'(row);
    it.column = ROW_W'(column);
    it.drain = drain_next;
    drain_next = 1'b0;
    command_queue.push_back(it);
    return 1'b1;
  endfunction

  task automatic probe_some(int side, int row);
    int partner;
    for (int t = 0; t < 40; t++) begin
      partner = ($urandom_range(0, 1) == 0) ? recent_row[1 - side] : $urandom_range(0, DIM - 1);
      if (side == LEFT_SIDE ? queue_probe(row, partner) : queue_probe(partner, row)) break;
    end
  endtask

  // Write a run of consecutive rows in compressed-row form
  task automatic build_rows(int side, int r0, int count, int base, int max_len, int span,
                            bit shuffled);
    int ptr, len;
    bit [COL_W-1:0] col;
    ptr = base;
    recent_row[side] = r0;
    queue_load(start_code(side), r0, ptr, random64());
    for (int i = 0; i < count; i++) begin
      len = $urandom_range(0, max_len);
      if (ptr + len > NNZ) len = NNZ - ptr;
      col = COL_W'($urandom_range(0, span));
      for (int j = 0; j < len; j++) begin
        if (shuffled) col = COL_W'($urandom_range(0, 255));
        queue_load(entry_code(side), ptr, int'(column_code(col)), entry_pattern());
        col += COL_W'($urandom_range(1, span));
        ptr++;
      end
      queue_load(start_code(side), r0 + i + 1, ptr, random64());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present items at the falling edge, hold each until accepted
  spdm_item_t cmd_now;
  bit         cmd_loaded = 1'b0;
  int         gap_left = 0;
  int         quiet_run = 0;

  always @(negedge clk) begin : drive_proc
    bit present, fresh;
    present = 1'b0;
    fresh = 1'b0;
    if (!rst) begin
      if (start && !item_taken) begin
        present = 1'b1;
      end else begin
        if (!cmd_loaded && command_queue.size() != 0) begin
          cmd_now = command_queue.pop_front();
          cmd_loaded = 1'b1;
          if (quiet_run != 0) begin
            quiet_run--;
            gap_left = 0;
          end else begin
            gap_left = $urandom_range(0, 12);
            if ($urandom_range(0, 39) == 0) quiet_run = $urandom_range(20, 60);
          end
        end
        // a drain item waits for every outstanding result first
        if (cmd_loaded && !(cmd_now.drain && bits_due.size() != 0)) begin
          if (gap_left != 0) begin
            gap_left--;
          end else begin
            present = 1'b1;
            fresh = 1'b1;
            cmd_loaded = 1'b0;
          end
        end
      end
    end
    start <= present;
    if (fresh) begin
      action <= cmd_now.act;
      slot <= cmd_now.addr;
      index_value <= cmd_now.val;
      entry_bits <= cmd_now.bits;
      out_row <= cmd_now.row;
      out_column <= cmd_now.column;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results, then fold accepted items into the predictor
  always @(posedge clk) begin : watch_proc
    bit [BITS_W-1:0] want;
    item_taken = 1'b0;
    if (!rst) begin
      if (done === 1'b1) begin
        results_checked++;
        if (bits_due.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing outstanding, expected none, got %h",
                   $time, dependency_bits);
        end else begin
          want = bits_due.pop_front();
          if (dependency_bits !== want) begin
            error_count++;
            if (error_count <= 200)
              $display("%0t: dependency_bits mismatch, expected %h, got %h",
                       $time, want, dependency_bits);
          end
        end
      end else if (done !== 1'b0) begin
        error_count++;
        $display("%0t: done unknown, expected 0 or 1, got %b", $time, done);
      end
      if (start && !busy) begin
        item_taken = 1'b1;
        accepted_count++;
        absorb_item(action, slot, index_value, entry_bits, out_row, out_column);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles without finishing", CYCLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan and end of run
  initial begin : plan_proc
    int pick, lc, rc, lr0, rr0, side, r, hi, lo, len, next_drain;
    bit [COL_W-1:0] col;

    // left row 0 = {1, 3, 5}, right row 0 = {3, 5, 7}
    queue_load(ACT_LOAD_LEFT_START, 0, 0, '0);
    queue_load(ACT_LOAD_LEFT_START, 1, 3, '1);
    queue_load(ACT_LOAD_LEFT_ENTRY, 0, 1, '1);
    queue_load(ACT_LOAD_LEFT_ENTRY, 1, 11'h703, 64'h1);
    queue_load(ACT_LOAD_LEFT_ENTRY, 2, 5, '0);
    queue_load(ACT_LOAD_RIGHT_START, 0, 0, random64());
    queue_load(ACT_LOAD_RIGHT_START, 1, 3, random64());
    queue_load(ACT_LOAD_RIGHT_ENTRY, 0, 3, '0);
    queue_load(ACT_LOAD_RIGHT_ENTRY, 1, 5, 64'h8000_0000_0000_0000);
    queue_load(ACT_LOAD_RIGHT_ENTRY, 2, 7, 64'hFFFF_FFFF_0000_0000);
    void'(queue_probe(0, 0));
    // left row 255: unsorted {7, 3, 5} at the top of the store, end pointer past it
    queue_load(ACT_LOAD_LEFT_START, 255, 1021, random64());
    queue_load(ACT_LOAD_LEFT_START, 256, 2047, random64());
    queue_load(ACT_LOAD_LEFT_ENTRY, 1021, 7, 64'h2);
    queue_load(ACT_LOAD_LEFT_ENTRY, 1022, 3, 64'h4);
    queue_load(ACT_LOAD_LEFT_ENTRY, 1023, 5, 64'h8);
    // right row 255: start above end, so empty
    queue_load(ACT_LOAD_RIGHT_START, 255, 5, random64());
    queue_load(ACT_LOAD_RIGHT_START, 256, 2, random64());
    void'(queue_probe(255, 0));
    void'(queue_probe(255, 255));
    // out-of-range slots and unused actions must leave the stores alone
    queue_load(ACT_LOAD_LEFT_START, 257, 0, '1);
    queue_load(ACT_LOAD_RIGHT_ENTRY, 1024, 3, '1);
    queue_load(ACT_LOAD_LEFT_ENTRY, 2047, 2047, '1);
    queue_load(ACT_UNUSED_LO, 0, 0, '1);
    queue_load(ACT_UNUSED_HI, 2047, 2047, random64());
    void'(queue_probe(0, 0));
    void'(queue_probe(255, 0));
    recent_row[LEFT_SIDE] = 0;
    recent_row[RIGHT_SIDE] = 0;
    drain_next = 1'b1;
    next_drain = DRAIN_EVERY;

    while (command_queue.size() < ITEM_TARGET) begin
      if (command_queue.size() >= next_drain) begin
        drain_next = 1'b1;
        next_drain += DRAIN_EVERY;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        lc = $urandom_range(1, 4);
        rc = $urandom_range(1, 4);
        lr0 = ($urandom_range(0, 7) == 0) ? DIM - lc : $urandom_range(0, DIM - lc);
        rr0 = ($urandom_range(0, 7) == 0) ? DIM - rc : $urandom_range(0, DIM - rc);
        build_rows(LEFT_SIDE, lr0, lc,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(1000, NNZ) : $urandom_range(0, 300),
                   ($urandom_range(0, 9) == 0) ? 16 : 5,
                   ($urandom_range(0, 1) == 0) ? 2 : $urandom_range(3, 40),
                   $urandom_range(0, 9) == 0);
        build_rows(RIGHT_SIDE, rr0, rc,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(1000, NNZ) : $urandom_range(0, 300),
                   ($urandom_range(0, 9) == 0) ? 16 : 5,
                   ($urandom_range(0, 1) == 0) ? 2 : $urandom_range(3, 40),
                   $urandom_range(0, 9) == 0);
        repeat ($urandom_range(1, 6))
          void'(queue_probe($urandom_range(lr0, lr0 + lc - 1), $urandom_range(rr0, rr0 + rc - 1)));
      end else if (pick < 80) begin
        queue_load(ACT_W'($urandom_range(ACT_LOAD_LEFT_START, ACT_LOAD_RIGHT_ENTRY)),
                   ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, DIM),
                   $urandom_range(0, 2047), random64());
      end else if (pick < 85) begin
        queue_load(ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)), $urandom_range(0, 2047),
                   $urandom_range(0, 2047), random64());
      end else if (pick < 90) begin
        // empty or inverted row
        side = $urandom_range(0, 1);
        r = $urandom_range(0, DIM - 1);
        hi = $urandom_range(1, 2047);
        lo = $urandom_range(0, hi);
        queue_load(start_code(side), r, hi, random64());
        queue_load(start_code(side), r + 1, lo, random64());
        probe_some(side, r);
      end else if (pick < 95) begin
        // row whose end pointer runs past the store
        side = $urandom_range(0, 1);
        r = $urandom_range(0, DIM - 1);
        len = $urandom_range(1, 4);
        col = COL_W'($urandom_range(0, 4));
        for (int k = NNZ - len; k < NNZ; k++) begin
          queue_load(entry_code(side), k, int'(column_code(col)), entry_pattern());
          col += COL_W'($urandom_range(1, 3));
        end
        queue_load(start_code(side), r, NNZ - len, random64());
        queue_load(start_code(side), r + 1, $urandom_range(NNZ + 1, 2047), random64());
        recent_row[side] = r;
        probe_some(side, r);
      end else begin
        probe_some($urandom_range(0, 1), $urandom_range(0, DIM - 1));
      end
    end
    planned_count = command_queue.size();

    while (accepted_count != planned_count || bits_due.size() != 0) @(negedge clk);
    repeat (64) @(posedge clk);
    $display("Drove %0d items (%0d merge computes, the rest loads and no-ops);",
             accepted_count, compute_count);
    $display("checked %0d dependency results, %0d errors.", results_checked, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sparse_product_dependency_merge_top.f -----
+incdir+hdl
hdl/spdm_pkg.sv
hdl/spdm_ptr_unit.sv
hdl/spdm_merge_unit.sv
hdl/sparse_product_dependency_merge_top.sv
sim/tb_top.sv
